@@ sv/i3fst_pkg.sv @@
// i3fst_pkg: shared constants, types and register codes of the 3x3 image filter
// used by all i3fst modules but i3fst_ram, and by the top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package i3fst_pkg;

   // line memory depth and geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int CFG_W       = 11;
   localparam int DIM_W       = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
   localparam int ROW_W       = 11;

   localparam logic [ROW_W-1:0] ROW_LIMIT    = 11'd2047;
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

   localparam int PIX_W      = 8;
   localparam int MODE_W     = 2;
   localparam int THR_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // floor(s / 9) == (s * 7282) >> 16 for every 9-tap sum of 8-bit pixels
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;
   localparam int MEAN_SHIFT = 16;

   // filter modes
   localparam logic [MODE_W-1:0] MODE_MEAN    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [TAPS-1:0] taps_type;

   // one accepted transaction, as it leaves the position tracker
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      pix_type           pix;
      logic              emit;
      logic              frame_end;
      logic [TAPS-1:0]   mask;
   } pos_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [THR_W-1:0]  threshold;
   } cfg_type;

   typedef struct packed {
      taps_type taps;
      logic     frame_end;
   } win_out_type;

endpackage

`default_nettype wire

@@ sv/i3fst_ram.sv @@
// i3fst_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module i3fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/i3fst_ctrl.sv @@
// i3fst_ctrl: control registers and raster position tracking, decides per transaction
// the line memory column, whether a result is due, the padding mask and frame end
// depends on i3fst_pkg
`timescale 1ns / 1ps
`default_nettype none

module i3fst_ctrl
   import i3fst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [PIX_W-1:0]      req_pixel_in,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  win_ready,
   output logic                       acc,
   output pos_type                    pos,
   output cfg_type                    cfg
);

   logic [MODE_W-1:0] filter_mode_ff;
   logic [CFG_W-1:0]  frame_width_ff;
   logic [CFG_W-1:0]  frame_height_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [DIM_W-1:0]  in_column_ff, in_column_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;

   logic [DIM_W-1:0]  w_eff, fw, ic, cc;
   logic [CFG_W-1:0]  h_eff;
   logic [ROW_W-1:0]  ir, cr;
   logic [DIM_W:0]    col_idx;
   logic [ROW_W:0]    row_idx;
   logic [KERNEL_SIZE-1:0] row_ok, col_ok;
   logic              emit, frame_end;

   assign csr_ready = 1'b1;
   assign req_ready = win_ready;
   assign acc       = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= MODE_MEAN;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         threshold_ff    <= 17'd16256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:      filter_mode_ff  <= csr_data[MODE_W-1:0];
            CSR_WIDTH:     frame_width_ff  <= csr_data[CFG_W-1:0];
            CSR_HEIGHT:    frame_height_ff <= csr_data[CFG_W-1:0];
            CSR_THRESHOLD: threshold_ff    <= csr_data[THR_W-1:0];
            default:       filter_mode_ff  <= filter_mode_ff;
         endcase
      end
   end

   always_comb begin
      // effective geometry
      fw = DIM_W'(frame_width_ff);
      if (fw == '0) begin
         w_eff = DIM_W'(1);
      end else if (fw > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = fw;
      end
      if (frame_height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = frame_height_ff;
      end

      // column wraps to the next row once it reaches the width
      if (in_column_ff >= w_eff) begin
         ic = '0;
         ir = (in_row_ff < ROW_LIMIT) ? in_row_ff + ROW_W'(1) : in_row_ff;
      end else begin
         ic = in_column_ff;
         ir = in_row_ff;
      end

      // first column of a row finishes the last centre of the row two above
      if (ic == '0) begin
         emit = (ir >= ROW_W'(2));
         cr   = ir - ROW_W'(2);
         cc   = w_eff - DIM_W'(1);
      end else begin
         emit = (ir >= ROW_W'(1));
         cr   = ir - ROW_W'(1);
         cc   = ic - DIM_W'(1);
      end

      for (int k = 0; k < KERNEL_SIZE; k++) begin
         row_idx   = {1'b0, cr} + (ROW_W + 1)'(k);
         col_idx   = {1'b0, cc} + (DIM_W + 1)'(k);
         row_ok[k] = (row_idx >= (ROW_W + 1)'(1)) && (row_idx <= (ROW_W + 1)'(h_eff));
         col_ok[k] = (col_idx >= (DIM_W + 1)'(1)) && (col_idx <= {1'b0, w_eff});
      end

      frame_end = emit && ({1'b0, cr} >= (ROW_W + 1)'(h_eff - CFG_W'(1)))
                  && (cc == w_eff - DIM_W'(1));

      pos.addr      = ic[ADDR_W-1:0];
      pos.pix       = req_op ? PIX_MIN : req_pixel_in;
      pos.emit      = emit;
      pos.frame_end = frame_end;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            pos.mask[r * KERNEL_SIZE + c] = row_ok[r] && col_ok[c];
         end
      end

      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      if (acc) begin
         in_column_in = frame_end ? '0 : ic + DIM_W'(1);
         in_row_in    = frame_end ? '0 : ir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
      end
   end

   assign cfg.mode      = filter_mode_ff;
   assign cfg.threshold = threshold_ff;

endmodule

`default_nettype wire

@@ sv/i3fst_window.sv @@
// i3fst_window: line memory read-modify-write and the 3x3 window registers,
// hands masked window taps to the arithmetic pipeline
// depends on i3fst_pkg and i3fst_ram
`timescale 1ns / 1ps
`default_nettype none

module i3fst_window
   import i3fst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    acc,
   input  wire pos_type pos,
   output logic         win_ready,
   output logic         k_valid,
   input  wire logic    k_ready,
   output win_out_type  k_data
);

   localparam int ENTRY_W = 2 * PIX_W;

   pos_type                s1_pos_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   fwd_ff;
   logic [ENTRY_W-1:0]     fwd_data_ff;
   taps_type               win_ff, win_in;

   logic [ENTRY_W-1:0]     ram_rd_data, rd_entry, wr_data;
   pix_type                rd_top, rd_mid;
   logic                   s1_go;

   // entry holds {two rows up, one row up} for its column
   i3fst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_pos_ff.addr),
      .wr_data (wr_data),
      .rd_en   (acc),
      .rd_addr (pos.addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rd_entry  = fwd_ff ? fwd_data_ff : ram_rd_data;
      rd_top    = rd_entry[ENTRY_W-1:PIX_W];
      rd_mid    = rd_entry[PIX_W-1:0];
      wr_data   = {rd_mid, s1_pos_ff.pix};
      s1_go     = s1_valid_ff && (!s1_pos_ff.emit || k_ready);
      win_ready = !s1_valid_ff || s1_go;

      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      win_in = win_ff;
      if (s1_go) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
               win_in[r * KERNEL_SIZE + c] = win_ff[r * KERNEL_SIZE + c + 1];
            end
         end
         win_in[KERNEL_SIZE - 1]         = rd_top;
         win_in[2 * KERNEL_SIZE - 1]     = rd_mid;
         win_in[3 * KERNEL_SIZE - 1]     = s1_pos_ff.pix;
      end

      // the shifted window is the neighborhood in every case: padding zeroes the rest
      for (int i = 0; i < TAPS; i++) begin
         k_data.taps[i] = s1_pos_ff.mask[i] ? win_in[i] : PIX_MIN;
      end
      k_data.frame_end = s1_pos_ff.frame_end;
      k_valid          = s1_valid_ff && s1_pos_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
      end
   end

   // same column written back in the cycle it is read again (one-pixel rows)
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (acc) begin
         fwd_ff <= s1_go && (s1_pos_ff.addr == pos.addr);
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pos_ff   <= pos;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/i3fst_kernel.sv @@
// i3fst_kernel: pipelined mean / sharpen / sobel arithmetic and the result register
// depends on i3fst_pkg
`timescale 1ns / 1ps
`default_nettype none

module i3fst_kernel
   import i3fst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        k_valid,
   output logic             k_ready,
   input  wire win_out_type k_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_frame_end
);

   localparam int GRAD_W = PIX_W + 2;
   localparam int SQ_W   = 2 * PIX_W;

   function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] a,
                                                 input logic [GRAD_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // stage a: taps
   logic        a_valid_ff;
   taps_type    a_taps_ff;
   logic        a_end_ff;
   // stage b: sums and gradients
   logic        b_valid_ff;
   logic [SUM_W-1:0] b_sum_ff, b_sum_in;
   pix_type     b_sharp_ff, b_sharp_in, b_gx_ff, b_gx_in, b_gy_ff, b_gy_in;
   logic        b_end_ff;
   // stage c: products
   logic        c_valid_ff;
   logic [SQ_W-1:0]   c_sqx_ff, c_sqy_ff;
   logic [PROD_W-1:0] c_prod_ff;
   pix_type     c_sharp_ff;
   logic        c_end_ff;
   // result register
   logic        out_valid_ff;
   pix_type     out_pixel_ff, out_pixel_in;
   logic        out_end_ff;

   logic        out_free, c_go, c_free, b_go, b_free, a_go, a_free;
   logic [GRAD_W-1:0] gx_p, gx_q, gy_p, gy_q, sh_c, sh_n, gx_d, gy_d, sh_d;
   logic [THR_W-1:0]  mag;

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      c_go     = c_valid_ff && out_free;
      c_free   = !c_valid_ff || c_go;
      b_go     = b_valid_ff && c_free;
      b_free   = !b_valid_ff || b_go;
      a_go     = a_valid_ff && b_free;
      a_free   = !a_valid_ff || a_go;
      k_ready  = a_free;
   end

   always_comb begin
      b_sum_in = '0;
      for (int i = 0; i < TAPS; i++) begin
         b_sum_in = b_sum_in + SUM_W'(a_taps_ff[i]);
      end
      sh_c = {a_taps_ff[4], 2'b00};
      sh_n = GRAD_W'(a_taps_ff[1]) + GRAD_W'(a_taps_ff[3])
           + GRAD_W'(a_taps_ff[5]) + GRAD_W'(a_taps_ff[7]);
      gx_p = GRAD_W'(a_taps_ff[2]) + {1'b0, a_taps_ff[5], 1'b0} + GRAD_W'(a_taps_ff[8]);
      gx_q = GRAD_W'(a_taps_ff[0]) + {1'b0, a_taps_ff[3], 1'b0} + GRAD_W'(a_taps_ff[6]);
      gy_p = GRAD_W'(a_taps_ff[6]) + {1'b0, a_taps_ff[7], 1'b0} + GRAD_W'(a_taps_ff[8]);
      gy_q = GRAD_W'(a_taps_ff[0]) + {1'b0, a_taps_ff[1], 1'b0} + GRAD_W'(a_taps_ff[2]);
      sh_d = abs_diff(sh_c, sh_n);
      gx_d = abs_diff(gx_p, gx_q);
      gy_d = abs_diff(gy_p, gy_q);
      // all three differences stay below 1024, so the quarter fits 8 bits
      b_sharp_in = sh_d[GRAD_W-1:2];
      b_gx_in    = gx_d[GRAD_W-1:2];
      b_gy_in    = gy_d[GRAD_W-1:2];
   end

   always_comb begin
      mag = THR_W'(c_sqx_ff) + THR_W'(c_sqy_ff);
      case (cfg.mode)
         MODE_SHARPEN: out_pixel_in = c_sharp_ff;
         MODE_SOBEL:   out_pixel_in = (mag >= cfg.threshold) ? PIX_MAX : PIX_MIN;
         default:      out_pixel_in = c_prod_ff[MEAN_SHIFT +: PIX_W];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= k_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_free) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (k_valid && a_free) begin
         a_taps_ff <= k_data.taps;
         a_end_ff  <= k_data.frame_end;
      end
      if (a_go) begin
         b_sum_ff   <= b_sum_in;
         b_sharp_ff <= b_sharp_in;
         b_gx_ff    <= b_gx_in;
         b_gy_ff    <= b_gy_in;
         b_end_ff   <= a_end_ff;
      end
      if (b_go) begin
         c_sqx_ff   <= SQ_W'(b_gx_ff) * SQ_W'(b_gx_ff);
         c_sqy_ff   <= SQ_W'(b_gy_ff) * SQ_W'(b_gy_ff);
         c_prod_ff  <= PROD_W'(b_sum_ff) * PROD_W'(MEAN_RECIP);
         c_sharp_ff <= b_sharp_ff;
         c_end_ff   <= b_end_ff;
      end
      if (c_go) begin
         out_pixel_ff <= out_pixel_in;
         out_end_ff   <= c_end_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

`default_nettype wire

@@ sv/image_3x3_filter_sobel_threshold.sv @@
// image_3x3_filter_sobel_threshold: 3x3 mean / sharpen / sobel threshold over a pixel stream
// depends on i3fst_pkg, i3fst_ctrl, i3fst_window, i3fst_kernel, i3fst_ram
//
//   port group  direction  transaction carries
//   req_*       in         op (pixel or flush), pixel_in
//   rsp_*       out        pixel_out, frame_end
//   csr_*       in         register index, write data
//
// one pixel per clock sustained while rsp_ready holds; rsp_valid rises once the transaction
// completing its window has passed the line ram read, then tap, sum and product stages,
// then the result register
// reset clears registers, position counters and window; the line ram is not cleared
// a stalled rsp side fills the pipeline bubbles first, then req_ready drops
`timescale 1ns / 1ps
`default_nettype none

module image_3x3_filter_sobel_threshold
   import i3fst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [PIX_W-1:0]      req_pixel_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PIX_W-1:0]           rsp_pixel_out,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic        acc, win_ready, k_valid, k_ready;
   pos_type     pos;
   cfg_type     cfg;
   win_out_type k_data;

   i3fst_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_pixel_in (req_pixel_in),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .win_ready    (win_ready),
      .acc          (acc),
      .pos          (pos),
      .cfg          (cfg)
   );

   i3fst_window u_window (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .pos       (pos),
      .win_ready (win_ready),
      .k_valid   (k_valid),
      .k_ready   (k_ready),
      .k_data    (k_data)
   );

   i3fst_kernel u_kernel (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .k_valid       (k_valid),
      .k_ready       (k_ready),
      .k_data        (k_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire
